>>> sv/ovn_pkg.sv
// ----------------------------------------------------------------------------
// ovn_pkg: shared types and constants for the octave value noise block
// Holds the sequencer state encoding, the fixed field widths, the request kinds and the register indexes.
// ----------------------------------------------------------------------------
package ovn_pkg;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned OUT_W   = 16;

  // request kinds carried in tuser
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_FREQ = 2'd1;
  localparam logic [1:0] REG_OCT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FADE1,
    ST_FADE2,
    ST_FADE3,
    ST_LOOK,
    ST_BLEND,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } ovn_state_t;

endpackage

>>> sv/ovn_perm_mem.sv
// ----------------------------------------------------------------------------
// ovn_perm_mem: permutation table storage
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ovn_perm_mem import ovn_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [0:(1<<IDX_W)-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ovn_divider.sv
// ----------------------------------------------------------------------------
// ovn_divider: radix-2 restoring divider
// Computes num / den, one quotient bit a cycle, for the final normalization.
// done rises when the quotient is ready and stays high until the next start.
// ----------------------------------------------------------------------------
module ovn_divider import ovn_pkg::*; #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    trial    = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // shift in one numerator bit, subtract when it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> sv/octave_value_noise_2d.sv
// ----------------------------------------------------------------------------
// octave_value_noise_2d: fractal 2-D value noise with smoothstep blending
// A load transaction (tuser = 0) writes one permutation byte when it is accepted.
// A sample transaction (tuser = 1) runs the scale state, then per octave the
// smoothstep states, the lookup and blend steps and the accumulate state, then
// the divider: per octave, eight dependent reads through the single read port
// of the permutation memory (address, registered read data) set the pace;
// the final normalization runs on a bit-serial divider of one quotient bit a
// cycle. One item is in flight at a time; the next transaction is accepted
// once the sequencer has gone from ST_OUT back to ST_IDLE.
// The result sits in an output register so the next item is accepted while
// it waits.
// ----------------------------------------------------------------------------
module octave_value_noise_2d import ovn_pkg::*; #(
  parameter int unsigned MAX_OCTAVES   = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: entry_index[7:0], entry_value[15:8], x_coord[27:16], y_coord[39:28]
  input  logic [39:0] in_tdata,
  // tuser: req_type
  input  logic        in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: noise_value[15:0]
  output logic [15:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned POS_W = 8 + FB;
  localparam int unsigned FREQ_W = 8 + FB;
  localparam int unsigned OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned SUM_W = 8 + FB + MAX_OCTAVES + 1;
  localparam int unsigned DEN_W = MAX_OCTAVES + FB - 8 + 1;
  localparam logic [FB:0] ONE   = (FB+1)'(1) << FB;

  // ---------------- configuration registers
  logic [7:0]        seed_r;
  logic [FREQ_W-1:0] freq_r;
  logic [3:0]        oct_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 8'd1;
      freq_r <= FREQ_W'(1) << FB;
      oct_r  <= 4'd4;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_SEED: seed_r <= cfg_pwdata[7:0];
        REG_FREQ: freq_r <= cfg_pwdata[FREQ_W-1:0];
        REG_OCT:  oct_r  <= cfg_pwdata[3:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SEED: cfg_prdata = {24'd0, seed_r};
      REG_FREQ: cfg_prdata = 32'(freq_r);
      REG_OCT:  cfg_prdata = {28'd0, oct_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer registers
  ovn_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic [COORD_W-1:0] xc_r, xc_nxt, yc_r, yc_nxt;
  logic [OCT_W-1:0]  n_r, n_nxt, oi_r, oi_nxt;
  logic [3:0]        step_r, step_nxt;
  logic [FB-1:0]     fx_r, fx_nxt, fy_r, fy_nxt;   // q terms
  logic [FB:0]       wx_r, wx_nxt, wy_r, wy_nxt;
  logic [7:0]        c_r [0:3];
  logic [7:0]        c_nxt [0:3];
  logic [8+FB-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [OUT_W-1:0]  res_r, res_nxt;
  logic              ov_r, ov_nxt;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  ovn_perm_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_tdata[7:0]),
    .wdata (in_tdata[15:8]),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // divider for normalization
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  ovn_divider #(.NUM_W(SUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // (2^n - 1) << (FB-8); the numerator includes the last octave's term
  assign div_den = DEN_W'(((DEN_W)'(1) << n_r) - 1'b1) << (FB - 8);
  assign div_num = sum_nxt + SUM_W'(div_den >> 1);

  // ---------------- shared datapath helpers
  logic [2*FB-1:0]  sq;
  logic [FB+2:0]    tri_t;
  logic [2*FB+3:0]  wprod;
  logic [FB+1:0]    wround;
  logic [FB-1:0]    frac_sel;
  logic [FB-1:0]    q_sel;
  logic [FB:0]      w_clamp;
  logic [FB:0]      bw;
  logic [8+FB-1:0]  ba, bb;
  logic [8+2*FB+1:0] bsum;
  logic [8+FB-1:0]  bres;

  assign frac_sel = (state_r == ST_FADE1) ? px_r[FB-1:0] : py_r[FB-1:0];
  assign q_sel    = (state_r == ST_FADE2) ? fx_r : fy_r;
  assign sq       = frac_sel * frac_sel;
  // 3*2^FB - 2f
  assign tri_t    = (FB+3)'(3) * (FB+3)'(ONE) -
                    {2'b00, (state_r == ST_FADE2 ? px_r[FB-1:0] : py_r[FB-1:0]), 1'b0};
  assign wprod    = (2*FB+4)'(q_sel) * (2*FB+4)'(tri_t);
  assign wround   = (FB+2)'((wprod + (2*FB+4)'(ONE >> 1)) >> FB);
  assign w_clamp  = (wround > (FB+2)'(ONE)) ? ONE : wround[FB:0];

  // blend operands chosen by step
  always_comb begin
    case (step_r)
      4'd0:    begin ba = {c_r[0], FB'(0)}; bb = {c_r[1], FB'(0)}; bw = wx_r; end
      4'd1:    begin ba = {c_r[2], FB'(0)}; bb = {c_r[3], FB'(0)}; bw = wx_r; end
      default: begin ba = lo_r;             bb = hi_r;             bw = wy_r; end
    endcase
  end
  assign bsum = (8+2*FB+2)'(ba) * (8+2*FB+2)'(ONE - bw) +
                (8+2*FB+2)'(bb) * (8+2*FB+2)'(bw) + (8+2*FB+2)'(ONE >> 1);
  assign bres = (8+FB)'(bsum >> FB);

  // lattice lookup address sequence: even steps read first, odd read corner
  logic [7:0] xi, yi, xo, yo;
  assign xi = px_r[POS_W-1:FB];
  assign yi = py_r[POS_W-1:FB];
  assign xo = xi + {7'd0, step_r[1]};
  assign yo = yi + {7'd0, step_r[2]};

  assign in_tready = (state_r == ST_IDLE) || (state_r == ST_OUT && !ov_r);
  logic in_acc;
  assign in_acc = in_tvalid & in_tready;
  assign mem_we = in_acc & (in_tuser == REQ_LOAD);

  // ---------------- next state
  always_comb begin
    state_nxt = state_r;
    px_nxt = px_r; py_nxt = py_r; xc_nxt = xc_r; yc_nxt = yc_r;
    n_nxt = n_r; oi_nxt = oi_r; step_nxt = step_r;
    fx_nxt = fx_r; fy_nxt = fy_r; wx_nxt = wx_r; wy_nxt = wy_r;
    for (int k = 0; k < 4; k++) c_nxt[k] = c_r[k];
    lo_nxt = lo_r; hi_nxt = hi_r; sum_nxt = sum_r;
    res_nxt = res_r; ov_nxt = ov_r;
    mem_raddr = yo + seed_r;
    div_start = 1'b0;

    // output register drains independently
    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE, ST_OUT: begin
        if (state_r == ST_OUT) state_nxt = ST_IDLE;
        if (in_acc && in_tuser == REQ_SAMPLE) begin
          xc_nxt = in_tdata[27:16];
          yc_nxt = in_tdata[39:28];
          if (oct_r == 4'd0) n_nxt = OCT_W'(1);
          else if (32'(oct_r) > MAX_OCTAVES) n_nxt = OCT_W'(MAX_OCTAVES);
          else n_nxt = OCT_W'(oct_r);
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        px_nxt = POS_W'(xc_r * freq_r);
        py_nxt = POS_W'(yc_r * freq_r);
        oi_nxt = '0;
        sum_nxt = '0;
        state_nxt = ST_FADE1;
      end
      ST_FADE1: begin
        fx_nxt = FB'((sq + (2*FB)'(ONE >> 1)) >> FB);
        state_nxt = ST_FADE3;
      end
      ST_FADE3: begin
        fy_nxt = FB'((sq + (2*FB)'(ONE >> 1)) >> FB);
        state_nxt = ST_FADE2;
      end
      ST_FADE2: begin
        wx_nxt = w_clamp;
        step_nxt = '0;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        // steps 0..7: issue first read, then corner read, per corner
        if (step_r == 4'd0) wy_nxt = w_clamp;
        if (!step_r[0]) begin
          mem_raddr = yo + seed_r;
        end else begin
          mem_raddr = mem_rdata + xo;
        end
        if (step_r != 4'd0 && !step_r[0]) c_nxt[step_r[2:1] - 2'd1] = mem_rdata;
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd7) state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        if (step_r == 4'd8) begin
          c_nxt[3] = mem_rdata;
          step_nxt = '0;
        end else begin
          if (step_r == 4'd0) lo_nxt = bres;
          else if (step_r == 4'd1) hi_nxt = bres;
          else begin
            lo_nxt = bres;
            state_nxt = ST_ACC;
          end
          step_nxt = step_r + 1'b1;
        end
      end
      ST_ACC: begin
        sum_nxt = sum_r + (SUM_W'(lo_r) << (n_r - oi_r - 1'b1));
        px_nxt = px_r << 1;
        py_nxt = py_r << 1;
        oi_nxt = oi_r + 1'b1;
        if (oi_r + 1'b1 == n_r) begin
          state_nxt = ST_DIV;
          div_start = 1'b1;
        end else begin
          state_nxt = ST_FADE1;
        end
      end
      ST_DIV: begin
        if (div_done && !ov_nxt) begin
          res_nxt = (div_quo > SUM_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
          ov_nxt = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt; py_r <= py_nxt; xc_r <= xc_nxt; yc_r <= yc_nxt;
    n_r <= n_nxt; oi_r <= oi_nxt;
    fx_r <= fx_nxt; fy_r <= fy_nxt; wx_r <= wx_nxt; wy_r <= wy_nxt;
    for (int k = 0; k < 4; k++) c_r[k] <= c_nxt[k];
    lo_r <= lo_nxt; hi_r <= hi_nxt; sum_r <= sum_nxt; res_r <= res_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = res_r;

endmodule
